@@ design/b64d_pkg.sv @@
// Shared types for the base64 text decoder.
package b64d_pkg;

	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_BAD_LEN  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		status_t    status;
		logic       end_of_run;
	} result_t;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [1:0]              count;
		result_t [MAX_RES-1:0]   entry;
	} step_t;

endpackage

@@ design/b64d_core.sv @@
// Character decode, group assembly, run state and capacity checks.
module b64d_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic [15:0]     cfg_data,
	input  logic            item_fire,
	input  logic [7:0]      char_s1,
	input  logic            final_s1,
	output b64d_pkg::step_t step
);
	import b64d_pkg::*;

	localparam logic [7:0]  PAD_CHAR  = 8'h3D;
	localparam logic [15:0] CAP_RESET = 16'd256;
	localparam int          CW        = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;
	localparam logic [CW-1:0] CNT_MAX = {{(CW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= "A" && c <= "Z") d = c - 8'd65;
			else if (c >= "a" && c <= "z") d = c - 8'd71;
			else if (c >= "0" && c <= "9") d = c + 8'd4;
			else if (c == "+" || c == "-" || c == ".") d = 8'd62;
			else if (c == "/" || c == "," || c == "_") d = 8'd63;
			return d[5:0];
		end
	endfunction

	logic [17:0]           acc_q, acc_nx;
	logic [1:0]            gp_q, gp_nx;
	logic [1:0]            tp_q, tp_nx;
	logic [COUNT_BITS-1:0] dc_q, dc_nx;
	logic                  ovf_q, ovf_nx;
	logic [15:0]           cap_q;

	logic [5:0]    sx;
	logic [1:0]    pad_nx;
	logic [23:0]   word;
	logic [3:0]    fits;
	logic [CW-1:0] dc_w, cap_w;
	logic [1:0]    nb;
	logic [1:0]    n_emit;

	assign sx    = sextet_of(char_s1);
	assign word  = {acc_q, sx};
	assign dc_w  = CW'(dc_q);
	assign cap_w = CW'(cap_q);

	// fits[k]: k more bytes plus the terminator still fit
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			fits[k] = (dc_w + CW'(k) <= CNT_MAX) && (dc_w + CW'(k) + CW'(1) <= cap_w);
		end
	end

	always_comb begin
		if (char_s1 == PAD_CHAR) begin
			if (gp_q == 2'd0) pad_nx = 2'd1;
			else if (tp_q == 2'd3) pad_nx = 2'd3;
			else pad_nx = tp_q + 2'd1;
		end else begin
			pad_nx = 2'd0;
		end
	end

	assign nb = 2'd3 - pad_nx;
	assign n_emit = ovf_q ? 2'd0 : (2'(fits[1]) + 2'(fits[2]) + 2'(fits[3]));

	always_comb begin
		step   = '0;
		acc_nx = acc_q;
		gp_nx  = gp_q;
		tp_nx  = pad_nx;
		dc_nx  = dc_q;
		ovf_nx = ovf_q;
		for (int i = 0; i < MAX_RES; i++) begin
			step.entry[i].data_byte  = word[23-8*i -: 8];
			step.entry[i].status     = ST_DATA;
			step.entry[i].end_of_run = 1'b0;
		end
		if (gp_q != 2'd3) begin
			acc_nx = {acc_q[11:0], sx};
			gp_nx  = gp_q + 2'd1;
			if (final_s1) begin
				step.count               = 2'd1;
				step.entry[0].data_byte  = 8'h00;
				step.entry[0].status     = ST_BAD_LEN;
				step.entry[0].end_of_run = 1'b1;
				acc_nx = '0;
				gp_nx  = '0;
				tp_nx  = '0;
				dc_nx  = '0;
				ovf_nx = 1'b0;
			end
		end else begin
			acc_nx = '0;
			gp_nx  = '0;
			if (!final_s1) begin
				step.count = n_emit;
				dc_nx      = dc_q + COUNT_BITS'(n_emit);
				ovf_nx     = ovf_q || !fits[3];
			end else begin
				if (ovf_q || !fits[nb]) begin
					step.count               = 2'd1;
					step.entry[0].data_byte  = 8'h00;
					step.entry[0].status     = ST_OVERFLOW;
					step.entry[0].end_of_run = 1'b1;
				end else begin
					step.count = nb;
					for (int i = 0; i < MAX_RES; i++) begin
						step.entry[i].end_of_run = (2'(i + 1) == nb);
					end
				end
				tp_nx  = '0;
				dc_nx  = '0;
				ovf_nx = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			gp_q  <= '0;
			tp_q  <= '0;
			dc_q  <= '0;
			ovf_q <= 1'b0;
			cap_q <= CAP_RESET;
		end else begin
			if (item_fire) begin
				acc_q <= acc_nx;
				gp_q  <= gp_nx;
				tp_q  <= tp_nx;
				dc_q  <= dc_nx;
				ovf_q <= ovf_nx;
			end
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
		end
	end

endmodule

@@ design/b64d_fifo.sv @@
// Four-entry result queue, up to three pushes and one pop per cycle.
module b64d_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::step_t     push,
	output logic [2:0]          free_cnt,
	output logic                head_valid,
	input  logic                head_ready,
	output b64d_pkg::result_t   head
);
	import b64d_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	result_t        mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           pop;

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign pop        = head_valid && head_ready;
	assign free_cnt   = 3'(DEPTH) - 3'(cnt_q);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.count) begin
				mem_q[wr_q + AW'(i)] <= push.entry[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.count);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + (AW+1)'(push.count) - (AW+1)'(pop);
		end
	end

endmodule

@@ design/base64_text_decoder.sv @@
// Base64 text decoder top level.
// Usage:
//  - Input channel (in_valid/in_ready, text_char, final_char): one character per
//    transfer; final_char marks the last character of a string.
//  - Output channel (out_valid/out_ready, data_byte, status, end_of_run): one
//    decoded byte or one error status per transfer; end_of_run flags the last
//    result of a string.
//  - Config channel (cfg_valid/cfg_ready, cfg_data): writes the capacity in bytes,
//    terminator included; always ready. Write only while the decoder is idle.
//  - Throughput: one character per cycle sustained; each fourth character yields
//    up to three bytes, drained one per cycle from a four-entry result queue.
//  - Path: a character is held in the input register, and its results are then
//    written to the result queue; a result can leave as soon as it is offered.
//  - A character waits in the input register until the queue has room for all
//    of its results; a stalled receiver therefore backs up into in_ready.
//  - Reset clears run state and the queue, and sets capacity to 256.
module base64_text_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_char,
	input  logic        final_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic [1:0]  status,
	output logic        end_of_run
);
	import b64d_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       final_s1;
	step_t      step, push;
	logic [2:0] free_cnt;
	logic       adv;
	result_t    head;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (3'(step.count) <= free_cnt);
	assign in_ready  = !valid_s1 || adv;

	always_comb begin
		push = step;
		if (!adv) push.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1  <= text_char;
			final_s1 <= final_char;
		end
	end

	b64d_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.item_fire (adv),
		.char_s1   (char_s1),
		.final_s1  (final_s1),
		.step      (step)
	);

	b64d_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.free_cnt   (free_cnt),
		.head_valid (out_valid),
		.head_ready (out_ready),
		.head       (head)
	);

	assign data_byte  = head.data_byte;
	assign status     = 2'(head.status);
	assign end_of_run = head.end_of_run;

endmodule
